// ----- hw/rtl/ipv4dq_pkg.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types, codes and constants of the IPv4 dotted-quad parser.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned OCTET_W     = 8;
    localparam int unsigned FIELD_COUNT = 4;
    localparam int unsigned MAG_W       = 9;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 40;

    localparam logic [CHAR_W-1:0]  CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0]  CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE  = 8'h39;
    localparam logic [MAG_W-1:0]   MAG_SAT    = 9'd256;
    localparam logic [MAG_W-1:0]   OCTET_MAX  = 9'd255;
    localparam logic [2:0]         FIELDS_MAX = 3'd4;
    localparam logic [2:0]         LAST_FIELD = 3'd3;

    typedef enum logic [1:0] {
        PH_WS     = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef logic [FIELD_COUNT-1:0][OCTET_W-1:0] octets_t;

    typedef struct packed {
        logic [2:0]       field_index;
        phase_t           field_phase;
        logic [MAG_W-1:0] magnitude;
        logic             minus_seen;
        status_t          first_error;
        octets_t          octets;
    } parse_state_t;

    typedef struct packed {
        status_t status;
        octets_t octets;
    } result_t;

    localparam parse_state_t STATE_INIT = '{
        field_index: 3'd0,
        field_phase: PH_WS,
        magnitude:   '0,
        minus_seen:  1'b0,
        first_error: ST_OK,
        octets:      '0
    };

endpackage

// ----- hw/rtl/ipv4dq_step.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_step
// Per-character update of the parser state and result forming on the
// last character of a string.
// ----------------------------------------------------------------------------
module ipv4dq_step (
    input  ipv4dq_pkg::parse_state_t          state_cur,
    input  logic [ipv4dq_pkg::CHAR_W-1:0]     char_code,
    input  logic                              has_char,
    input  logic                              last,
    output ipv4dq_pkg::parse_state_t          state_next,
    output ipv4dq_pkg::result_t               result
);

    function automatic ipv4dq_pkg::parse_state_t judge(input ipv4dq_pkg::parse_state_t s);
        ipv4dq_pkg::parse_state_t r;
        logic                     can_note;
        r        = s;
        can_note = (s.first_error == ipv4dq_pkg::ST_OK) && (s.field_index < ipv4dq_pkg::FIELDS_MAX);
        if (s.field_phase == ipv4dq_pkg::PH_WS || s.field_phase == ipv4dq_pkg::PH_SIGN)
        begin
            if (can_note)
            begin
                r.first_error = ipv4dq_pkg::ST_EMPTY;
            end
        end
        else if (s.field_phase == ipv4dq_pkg::PH_DIGITS)
        begin
            if ((s.minus_seen && s.magnitude != '0) || s.magnitude > ipv4dq_pkg::OCTET_MAX)
            begin
                if (can_note)
                begin
                    r.first_error = ipv4dq_pkg::ST_RANGE;
                end
            end
            else if (s.field_index < ipv4dq_pkg::FIELDS_MAX)
            begin
                r.octets[s.field_index[1:0]] = s.magnitude[ipv4dq_pkg::OCTET_W-1:0];
            end
        end
        r.field_phase = ipv4dq_pkg::PH_DONE;
        return r;
    endfunction

    ipv4dq_pkg::parse_state_t s_char;
    ipv4dq_pkg::parse_state_t s_end;
    logic                     is_digit;
    logic                     is_space;
    logic [ipv4dq_pkg::MAG_W-1:0] digit_val;
    logic [11:0]              mag_acc;
    ipv4dq_pkg::status_t      status;

    assign is_digit  = (char_code >= ipv4dq_pkg::CHAR_ZERO) && (char_code <= ipv4dq_pkg::CHAR_NINE);
    assign is_space  = char_code inside {8'd32, [8'd9:8'd13]};
    assign digit_val = {1'b0, char_code - ipv4dq_pkg::CHAR_ZERO};
    assign mag_acc   = {state_cur.magnitude, 3'b000} + {2'b00, state_cur.magnitude, 1'b0}
                     + {3'b000, digit_val};

    always_comb
    begin
        s_char = state_cur;
        if (has_char)
        begin
            if (char_code == ipv4dq_pkg::CHAR_DOT)
            begin
                s_char = judge(state_cur);
                if (state_cur.field_index < ipv4dq_pkg::FIELDS_MAX)
                begin
                    s_char.field_index = state_cur.field_index + 3'd1;
                end
                s_char.field_phase = ipv4dq_pkg::PH_WS;
                s_char.magnitude   = '0;
                s_char.minus_seen  = 1'b0;
            end
            else
            begin
                case (state_cur.field_phase)
                    ipv4dq_pkg::PH_WS:
                    begin
                        if (is_space)
                        begin
                            s_char = state_cur;
                        end
                        else if (char_code == ipv4dq_pkg::CHAR_PLUS ||
                                 char_code == ipv4dq_pkg::CHAR_MINUS)
                        begin
                            s_char.minus_seen  = (char_code == ipv4dq_pkg::CHAR_MINUS);
                            s_char.field_phase = ipv4dq_pkg::PH_SIGN;
                        end
                        else if (is_digit)
                        begin
                            s_char.magnitude   = digit_val;
                            s_char.field_phase = ipv4dq_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            s_char = judge(state_cur);
                        end
                    end
                    ipv4dq_pkg::PH_SIGN:
                    begin
                        if (is_digit)
                        begin
                            s_char.magnitude   = digit_val;
                            s_char.field_phase = ipv4dq_pkg::PH_DIGITS;
                        end
                        else
                        begin
                            s_char = judge(state_cur);
                        end
                    end
                    ipv4dq_pkg::PH_DIGITS:
                    begin
                        if (is_digit)
                        begin
                            s_char.magnitude = (mag_acc > 12'(ipv4dq_pkg::MAG_SAT))
                                             ? ipv4dq_pkg::MAG_SAT : mag_acc[ipv4dq_pkg::MAG_W-1:0];
                        end
                        else
                        begin
                            s_char = judge(state_cur);
                        end
                    end
                    default:
                    begin
                        s_char = state_cur;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        s_end = judge(s_char);
        if (s_end.field_index != ipv4dq_pkg::LAST_FIELD)
        begin
            status = ipv4dq_pkg::ST_COUNT;
        end
        else
        begin
            status = s_end.first_error;
        end
        result.status = status;
        result.octets = (status == ipv4dq_pkg::ST_OK) ? s_end.octets : '0;
        state_next    = last ? ipv4dq_pkg::STATE_INIT : s_char;
    end

endmodule

// ----- hw/rtl/ipv4dq_out_reg.sv -----
// ----------------------------------------------------------------------------
// ipv4dq_out_reg
// Result register on the master-side stream; frees itself when taken.
// ----------------------------------------------------------------------------
module ipv4dq_out_reg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  ipv4dq_pkg::result_t                  result,
    output logic                                 slot_free,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status[1:0], octet_a[9:2], octet_b[17:10], octet_c[25:18], octet_d[33:26], zero
    output logic [ipv4dq_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                valid_reg;
    logic                valid_next;
    ipv4dq_pkg::result_t data_reg;

    assign slot_free  = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, data_reg.octets[3], data_reg.octets[2], data_reg.octets[1],
                       data_reg.octets[0], data_reg.status};

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n) load |-> slot_free)
        else $error("result loaded into occupied slot");
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n) load |=> valid_reg)
        else $error("loaded result not presented");
    a_zero_octets: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && data_reg.status != ipv4dq_pkg::ST_OK) |-> (data_reg.octets == '0))
        else $error("octets nonzero on failing status");

endmodule

// ----- hw/rtl/ipv4_dotted_quad_parser.sv -----
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// Parses an IPv4 dotted-decimal string, one character per transaction.
// ----------------------------------------------------------------------------
// One character per clock is accepted with no bubbles; each character goes
// through an input register and a state update; a string's result is loaded
// into the output register as its s_tlast character leaves the input register.
// The string ends at s_tlast; s_tuser low marks a transaction with no character.
// Results wait in an output register, so input keeps flowing while the last
// result is stalled, until a new s_tlast character reaches the update stage.
module ipv4_dotted_quad_parser (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // char_code[7:0]
    input  logic [ipv4dq_pkg::S_TDATA_W-1:0]     s_tdata,
    // has_char[0]
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status[1:0], octet_a[9:2], octet_b[17:10], octet_c[25:18], octet_d[33:26], zero
    output logic [ipv4dq_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                            in_valid_reg;
    logic [ipv4dq_pkg::CHAR_W-1:0]   in_char_reg;
    logic                            in_has_reg;
    logic                            in_last_reg;
    logic                            in_advance;
    logic                            slot_free;
    ipv4dq_pkg::parse_state_t        state_reg;
    ipv4dq_pkg::parse_state_t        state_next;
    ipv4dq_pkg::result_t             result;

    assign in_advance = in_valid_reg && (!in_last_reg || slot_free);
    assign s_tready   = !in_valid_reg || in_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= ipv4dq_pkg::STATE_INIT;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (in_advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_char_reg <= s_tdata;
            in_has_reg  <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    ipv4dq_step u_step (
        .state_cur  (state_reg),
        .char_code  (in_char_reg),
        .has_char   (in_has_reg),
        .last       (in_last_reg),
        .state_next (state_next),
        .result     (result)
    );

    ipv4dq_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_advance && in_last_reg),
        .result    (result),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
